// ===== rtl/core/dense_layer_sgd_train_top_macros.svh =====
// Assertion macros shared by the dense layer training block
`ifndef DENSE_LAYER_SGD_TRAIN_TOP_MACROS_SVH
`define DENSE_LAYER_SGD_TRAIN_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define DLST_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DLST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dlst_pkg.sv =====
// Shared types and constants of the dense layer training block
package dlst_pkg;

    localparam int IO_VALUE_BITS  = 16;
    localparam int FIELD_IDX_BITS = 5;
    localparam int LR_BITS        = 16;
    localparam int COUNT_BITS     = 6;
    localparam int CNT_BITS       = 7;
    localparam int ACC_BITS       = 64;
    localparam int FRAC_BITS      = 12;
    localparam int RESULT_LIMIT   = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [1:0] MODE_WEIGHT = 2'd0;
    localparam logic [1:0] MODE_BIAS   = 2'd1;
    localparam logic [1:0] MODE_FWD    = 2'd2;
    localparam logic [1:0] MODE_GRAD   = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEARN_RATE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IN_COUNT   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUT_COUNT  = 2'd2;

    localparam logic KIND_FWD  = 1'b0;
    localparam logic KIND_GRAD = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACC_BIAS,
        OP_ACC_ZERO,
        OP_MUL_WX,
        OP_MUL_WG,
        OP_ACC_ADD,
        OP_EMIT,
        OP_MUL_GX,
        OP_SPLIT,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_WUPD,
        OP_MUL_GLR,
        OP_BUPD
    } t_dp_op;

    typedef struct packed {
        t_dp_op                    op;
        logic                      kind;
        logic [FIELD_IDX_BITS-1:0] index;
        logic                      end_of_run;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/dlst_in_if.sv =====
// Input item channel
interface dlst_in_if import dlst_pkg::*; ();
    logic                             valid;
    logic                             ready;
    logic [1:0]                       mode;
    logic [FIELD_IDX_BITS-1:0]        row;
    logic [FIELD_IDX_BITS-1:0]        col;
    logic signed [IO_VALUE_BITS-1:0]  value;
    logic                             last;

    modport source (output valid, mode, row, col, value, last, input ready);
    modport sink   (input valid, mode, row, col, value, last, output ready);
endinterface

// ===== rtl/core/dlst_out_if.sv =====
// Result item channel
interface dlst_out_if import dlst_pkg::*; ();
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic [FIELD_IDX_BITS-1:0]        index;
    logic signed [IO_VALUE_BITS-1:0]  out_value;
    logic                             end_of_run;

    modport source (output valid, kind, index, out_value, end_of_run, input ready);
    modport sink   (input valid, kind, index, out_value, end_of_run, output ready);
endinterface

// ===== rtl/core/dlst_cfg_if.sv =====
// Configuration write channel
interface dlst_cfg_if import dlst_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dense_layer_sgd_train_top.sv =====
// Top level of the dense layer forward/backward block with SGD update
//
//  channel | dir | payload                              | transfer
//  i_in    | in  | mode, row, col, value, last          | valid && ready
//  o_out   | out | kind, index, out_value, end_of_run   | valid && ready
//  i_cfg   | in  | index, data                          | valid && ready
//
// Weight, bias and non-last items are taken without leaving the idle state.
// Last forward item: runs the forward pass on the single multiplier.
// Last gradient item: runs the backward pass, then the weight and bias update.
// Reset clears control state and restores configuration; stores hold garbage until written.
// A full result register stalls the sequencer in its emit state; i_in.ready is low while busy.
`include "dense_layer_sgd_train_top_macros.svh"

module dense_layer_sgd_train_top import dlst_pkg::*; #(
    parameter int MAX_IN     = 32,
    parameter int MAX_OUT    = 32,
    parameter int VALUE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dlst_in_if.sink     i_in,
    dlst_out_if.source  o_out,
    dlst_cfg_if.sink    i_cfg
);

    localparam int RAW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int CAW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;

    logic               w_in_ready, w_in_fire;
    logic [LR_BITS-1:0] w_learn_rate;
    logic [RAW-1:0]     w_row;
    logic [CAW-1:0]     w_col;
    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;

    assign i_in.ready = w_in_ready;
    assign w_in_fire  = i_in.valid && w_in_ready;

    dlst_ctrl #(
        .MAX_IN  (MAX_IN),
        .MAX_OUT (MAX_OUT),
        .RAW     (RAW),
        .CAW     (CAW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (w_in_ready),
        .i_in_mode    (i_in.mode),
        .i_in_last    (i_in.last),
        .i_cfg_valid  (i_cfg.valid),
        .o_cfg_ready  (i_cfg.ready),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_learn_rate (w_learn_rate),
        .o_row        (w_row),
        .o_col        (w_col),
        .o_cmd        (w_cmd),
        .i_stat       (w_stat)
    );

    dlst_dp #(
        .MAX_IN     (MAX_IN),
        .MAX_OUT    (MAX_OUT),
        .VALUE_BITS (VALUE_BITS),
        .RAW        (RAW),
        .CAW        (CAW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_fire    (w_in_fire),
        .i_in_mode    (i_in.mode),
        .i_in_row     (i_in.row),
        .i_in_col     (i_in.col),
        .i_in_value   (i_in.value),
        .i_learn_rate (w_learn_rate),
        .i_row        (w_row),
        .i_col        (w_col),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_kind   (o_out.kind),
        .o_out_index  (o_out.index),
        .o_out_value  (o_out.out_value),
        .o_out_end    (o_out.end_of_run)
    );

    `DLST_ASSERT_SAME(a_emit_into_free_reg, i_clk, i_rst_n, w_cmd.op == OP_EMIT, w_stat.out_free, "result loaded while register still full")
    `DLST_ASSERT_NEXT(a_store_write_no_stall, i_clk, i_rst_n, w_in_fire && !i_in.last, i_in.ready, "busy after a non-last item")
    `DLST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid, "waiting result dropped")

endmodule

// ===== rtl/core/dlst_dp.sv =====
// Datapath: stores, shared multiplier, accumulator and result register
module dlst_dp import dlst_pkg::*; #(
    parameter int MAX_IN     = 32,
    parameter int MAX_OUT    = 32,
    parameter int VALUE_BITS = 16,
    parameter int RAW        = 5,
    parameter int CAW        = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_fire,
    input  logic [1:0]                       i_in_mode,
    input  logic [FIELD_IDX_BITS-1:0]        i_in_row,
    input  logic [FIELD_IDX_BITS-1:0]        i_in_col,
    input  logic signed [IO_VALUE_BITS-1:0]  i_in_value,
    input  logic [LR_BITS-1:0]               i_learn_rate,
    input  logic [RAW-1:0]                   i_row,
    input  logic [CAW-1:0]                   i_col,
    input  t_dp_cmd                          i_cmd,
    output t_dp_stat                         o_stat,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_out_kind,
    output logic [FIELD_IDX_BITS-1:0]        o_out_index,
    output logic signed [IO_VALUE_BITS-1:0]  o_out_value,
    output logic                             o_out_end
);

    localparam int VB     = VALUE_BITS;
    localparam int MA0    = (2 * VB - 27 > VB) ? 2 * VB - 27 : VB;
    localparam int MA     = (MA0 > 29) ? MA0 : 29;
    localparam int MB     = (VB > LR_BITS + 1) ? VB : LR_BITS + 1;
    localparam int PW     = MA + MB;
    localparam int WDEPTH = MAX_OUT * MAX_IN;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int AFB    = 13;

    localparam logic signed [ACC_BITS-1:0] VMAX = (64'sd1 <<< (VB - 1)) - 64'sd1;
    localparam logic signed [ACC_BITS-1:0] VMIN = -VMAX - 64'sd1;
    localparam logic signed [ACC_BITS-1:0] ALIM = 64'sd1 <<< 61;
    localparam logic signed [ACC_BITS-1:0] HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] HALF_W = 64'sd1 <<< 27;
    localparam logic signed [ACC_BITS-1:0] HALF_B = 64'sd1 <<< 15;

    function automatic logic signed [ACC_BITS-1:0] f_sat(input logic signed [ACC_BITS-1:0] v);
        logic signed [ACC_BITS-1:0] r;
        r = v;
        if (v > VMAX) r = VMAX;
        if (v < VMIN) r = VMIN;
        return r;
    endfunction

    function automatic logic signed [ACC_BITS-1:0] f_clamp(input logic signed [ACC_BITS-1:0] v);
        logic signed [ACC_BITS-1:0] r;
        r = v;
        if (v > ALIM) r = ALIM;
        if (v < -ALIM) r = -ALIM;
        return r;
    endfunction

    logic signed [VB-1:0] mem_w [WDEPTH];
    logic signed [VB-1:0] mem_b [MAX_OUT];
    logic signed [VB-1:0] mem_x [MAX_IN];
    logic signed [VB-1:0] mem_g [MAX_OUT];

    logic signed [VB-1:0]       r_rd_w, r_rd_b, r_rd_x, r_rd_g;
    logic signed [PW-1:0]       r_prod;
    logic signed [ACC_BITS-1:0] r_acc;
    logic signed [MA-1:0]       r_hi;
    logic [27:0]                r_lo;
    logic [LR_BITS:0]           r_dlo;
    logic                       r_out_valid, r_out_kind, r_out_end;
    logic [FIELD_IDX_BITS-1:0]  r_out_index;
    logic signed [IO_VALUE_BITS-1:0] r_out_value;

    logic [CNT_BITS-1:0]        w_in_row7, w_in_col7;
    logic [AFB-1:0]             w_in_waddr, w_rd_waddr;
    logic signed [VB-1:0]       w_in_val;
    logic                       w_in_row_ok, w_in_col_ok;
    logic                       w_w_we, w_b_we;
    logic [WAW-1:0]             w_w_addr;
    logic [RAW-1:0]             w_b_addr;
    logic signed [VB-1:0]       w_w_data, w_b_data;
    logic signed [MA-1:0]       w_ma;
    logic signed [MB-1:0]       w_mb, w_lr;
    logic signed [PW-1:0]       w_prod;
    logic signed [ACC_BITS-1:0] w_p64, w_emit, w_wnew, w_bnew, w_sum;

    assign w_in_row7   = CNT_BITS'(i_in_row);
    assign w_in_col7   = CNT_BITS'(i_in_col);
    assign w_in_row_ok = w_in_row7 < CNT_BITS'(MAX_OUT);
    assign w_in_col_ok = w_in_col7 < CNT_BITS'(MAX_IN);
    assign w_in_val    = VB'(f_sat(ACC_BITS'(i_in_value)));
    assign w_in_waddr  = AFB'(i_in_row) * AFB'(MAX_IN) + AFB'(i_in_col);
    assign w_rd_waddr  = AFB'(i_row) * AFB'(MAX_IN) + AFB'(i_col);
    assign w_p64       = ACC_BITS'(r_prod);
    assign w_lr        = MB'({1'b0, i_learn_rate});

    assign w_emit = f_sat((r_acc + HALF_Q) >>> FRAC_BITS);
    assign w_wnew = f_sat(ACC_BITS'(r_rd_w) - (w_p64 + ACC_BITS'(r_dlo)));
    assign w_bnew = f_sat(ACC_BITS'(r_rd_b) - ((w_p64 + HALF_B) >>> 16));
    assign w_sum  = f_clamp(r_acc + f_clamp(w_p64));

    always_comb begin
        w_w_we   = 1'b0;
        w_w_addr = w_rd_waddr[WAW-1:0];
        w_w_data = VB'(w_wnew);
        if (i_in_fire && i_in_mode == MODE_WEIGHT && w_in_row_ok && w_in_col_ok) begin
            w_w_we   = 1'b1;
            w_w_addr = w_in_waddr[WAW-1:0];
            w_w_data = w_in_val;
        end else if (i_cmd.op == OP_WUPD) begin
            w_w_we = 1'b1;
        end
    end

    always_comb begin
        w_b_we   = 1'b0;
        w_b_addr = i_row;
        w_b_data = VB'(w_bnew);
        if (i_in_fire && i_in_mode == MODE_BIAS && w_in_row_ok) begin
            w_b_we   = 1'b1;
            w_b_addr = w_in_row7[RAW-1:0];
            w_b_data = w_in_val;
        end else if (i_cmd.op == OP_BUPD) begin
            w_b_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_w_we) begin
            mem_w[w_w_addr] <= w_w_data;
        end
        r_rd_w <= mem_w[w_rd_waddr[WAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_b_we) begin
            mem_b[w_b_addr] <= w_b_data;
        end
        r_rd_b <= mem_b[i_row];
    end

    always_ff @(posedge i_clk) begin
        if (i_in_fire && i_in_mode == MODE_FWD && w_in_col_ok) begin
            mem_x[w_in_col7[CAW-1:0]] <= w_in_val;
        end
        r_rd_x <= mem_x[i_col];
    end

    always_ff @(posedge i_clk) begin
        if (i_in_fire && i_in_mode == MODE_GRAD && w_in_row_ok) begin
            mem_g[w_in_row7[RAW-1:0]] <= w_in_val;
        end
        r_rd_g <= mem_g[i_row];
    end

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_MUL_WX: begin
                w_ma = MA'(r_rd_w);
                w_mb = MB'(r_rd_x);
            end
            OP_MUL_WG: begin
                w_ma = MA'(r_rd_w);
                w_mb = MB'(r_rd_g);
            end
            OP_MUL_GX: begin
                w_ma = MA'(r_rd_g);
                w_mb = MB'(r_rd_x);
            end
            OP_MUL_GLR: begin
                w_ma = MA'(r_rd_g);
                w_mb = w_lr;
            end
            OP_MUL_LO: begin
                w_ma = MA'({1'b0, r_lo});
                w_mb = w_lr;
            end
            OP_MUL_HI: begin
                w_ma = r_hi;
                w_mb = w_lr;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_MUL_WX, OP_MUL_WG, OP_MUL_GX, OP_MUL_GLR, OP_MUL_LO: begin
                r_prod <= w_prod;
            end
            OP_MUL_HI: begin
                r_prod <= w_prod;
                r_dlo  <= (LR_BITS + 1)'((w_p64 + HALF_W) >>> 28);
            end
            OP_SPLIT: begin
                r_hi <= MA'(w_p64 >>> 28);
                r_lo <= w_p64[27:0];
            end
            OP_ACC_BIAS: r_acc <= ACC_BITS'(r_rd_b) <<< FRAC_BITS;
            OP_ACC_ZERO: r_acc <= '0;
            OP_ACC_ADD:  r_acc <= w_sum;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_out_kind  <= i_cmd.kind;
            r_out_index <= i_cmd.index;
            r_out_end   <= i_cmd.end_of_run;
            r_out_value <= w_emit[IO_VALUE_BITS-1:0];
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_kind      = r_out_kind;
    assign o_out_index     = r_out_index;
    assign o_out_value     = r_out_value;
    assign o_out_end       = r_out_end;

endmodule

// ===== rtl/core/dlst_ctrl.sv =====
// Controller: configuration registers and the loop sequencer
module dlst_ctrl import dlst_pkg::*; #(
    parameter int MAX_IN  = 32,
    parameter int MAX_OUT = 32,
    parameter int RAW     = 5,
    parameter int CAW     = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_in_mode,
    input  logic                      i_in_last,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output logic [LR_BITS-1:0]        o_learn_rate,
    output logic [RAW-1:0]            o_row,
    output logic [CAW-1:0]            o_col,
    output t_dp_cmd                   o_cmd,
    input  t_dp_stat                  i_stat
);

    localparam int OUT_LIM = (MAX_OUT < RESULT_LIMIT) ? MAX_OUT : RESULT_LIMIT;
    localparam int IN_LIM  = (MAX_IN < RESULT_LIMIT) ? MAX_IN : RESULT_LIMIT;

    typedef enum logic [4:0] {
        S_IDLE,
        S_F_BRD, S_F_BLD, S_F_RD, S_F_MUL, S_F_ADD, S_F_EMIT,
        S_B_ZERO, S_B_RD, S_B_MUL, S_B_ADD, S_B_EMIT,
        S_U_BRD, S_U_BMUL, S_U_BUPD,
        S_U_RD, S_U_MUL, S_U_SPLIT, S_U_MLO, S_U_MHI, S_U_WUPD
    } t_state;

    t_state                r_state;
    logic [RAW-1:0]        r_i;
    logic [CAW-1:0]        r_j;
    logic [LR_BITS-1:0]    r_learn_rate;
    logic [COUNT_BITS-1:0] r_in_count, r_out_count;

    logic [CNT_BITS-1:0]   w_no, w_ni;
    logic                  w_i_last, w_j_last;

    assign w_no = (CNT_BITS'(r_out_count) > CNT_BITS'(OUT_LIM)) ?
                  CNT_BITS'(OUT_LIM) : CNT_BITS'(r_out_count);
    assign w_ni = (CNT_BITS'(r_in_count) > CNT_BITS'(IN_LIM)) ?
                  CNT_BITS'(IN_LIM) : CNT_BITS'(r_in_count);
    assign w_i_last = (CNT_BITS'(r_i) + CNT_BITS'(1)) == w_no;
    assign w_j_last = (CNT_BITS'(r_j) + CNT_BITS'(1)) == w_ni;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_i          <= '0;
            r_j          <= '0;
            r_learn_rate <= 16'd655;
            r_in_count   <= 6'd32;
            r_out_count  <= 6'd32;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LEARN_RATE: r_learn_rate <= i_cfg_data[LR_BITS-1:0];
                    CFG_IN_COUNT:   r_in_count   <= i_cfg_data[COUNT_BITS-1:0];
                    CFG_OUT_COUNT:  r_out_count  <= i_cfg_data[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_in_last) begin
                        r_i <= '0;
                        r_j <= '0;
                        if (i_in_mode == MODE_FWD && w_no != '0) begin
                            r_state <= S_F_BRD;
                        end else if (i_in_mode == MODE_GRAD && w_ni != '0) begin
                            r_state <= S_B_ZERO;
                        end else if (i_in_mode == MODE_GRAD && w_no != '0) begin
                            r_state <= S_U_BRD;
                        end
                    end
                end
                S_F_BRD: r_state <= S_F_BLD;
                S_F_BLD: begin
                    r_j     <= '0;
                    r_state <= (w_ni == '0) ? S_F_EMIT : S_F_RD;
                end
                S_F_RD:  r_state <= S_F_MUL;
                S_F_MUL: r_state <= S_F_ADD;
                S_F_ADD: begin
                    if (w_j_last) begin
                        r_state <= S_F_EMIT;
                    end else begin
                        r_j     <= r_j + CAW'(1);
                        r_state <= S_F_RD;
                    end
                end
                S_F_EMIT: begin
                    if (i_stat.out_free) begin
                        if (w_i_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + RAW'(1);
                            r_state <= S_F_BRD;
                        end
                    end
                end
                S_B_ZERO: begin
                    r_i     <= '0;
                    r_state <= (w_no == '0) ? S_B_EMIT : S_B_RD;
                end
                S_B_RD:  r_state <= S_B_MUL;
                S_B_MUL: r_state <= S_B_ADD;
                S_B_ADD: begin
                    if (w_i_last) begin
                        r_state <= S_B_EMIT;
                    end else begin
                        r_i     <= r_i + RAW'(1);
                        r_state <= S_B_RD;
                    end
                end
                S_B_EMIT: begin
                    if (i_stat.out_free) begin
                        if (w_j_last) begin
                            r_i     <= '0;
                            r_state <= (w_no == '0) ? S_IDLE : S_U_BRD;
                        end else begin
                            r_j     <= r_j + CAW'(1);
                            r_state <= S_B_ZERO;
                        end
                    end
                end
                S_U_BRD:  r_state <= S_U_BMUL;
                S_U_BMUL: r_state <= S_U_BUPD;
                S_U_BUPD: begin
                    r_j <= '0;
                    if (w_ni != '0) begin
                        r_state <= S_U_RD;
                    end else if (w_i_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + RAW'(1);
                        r_state <= S_U_BRD;
                    end
                end
                S_U_RD:    r_state <= S_U_MUL;
                S_U_MUL:   r_state <= S_U_SPLIT;
                S_U_SPLIT: r_state <= S_U_MLO;
                S_U_MLO:   r_state <= S_U_MHI;
                S_U_MHI:   r_state <= S_U_WUPD;
                S_U_WUPD: begin
                    if (!w_j_last) begin
                        r_j     <= r_j + CAW'(1);
                        r_state <= S_U_RD;
                    end else if (w_i_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + RAW'(1);
                        r_state <= S_U_BRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.op         = OP_NONE;
        unique case (r_state)
            S_F_BLD:  o_cmd.op = OP_ACC_BIAS;
            S_F_MUL:  o_cmd.op = OP_MUL_WX;
            S_F_ADD,
            S_B_ADD:  o_cmd.op = OP_ACC_ADD;
            S_F_EMIT: begin
                o_cmd.op         = i_stat.out_free ? OP_EMIT : OP_NONE;
                o_cmd.kind       = KIND_FWD;
                o_cmd.index      = FIELD_IDX_BITS'(r_i);
                o_cmd.end_of_run = w_i_last;
            end
            S_B_ZERO: o_cmd.op = OP_ACC_ZERO;
            S_B_MUL:  o_cmd.op = OP_MUL_WG;
            S_B_EMIT: begin
                o_cmd.op         = i_stat.out_free ? OP_EMIT : OP_NONE;
                o_cmd.kind       = KIND_GRAD;
                o_cmd.index      = FIELD_IDX_BITS'(r_j);
                o_cmd.end_of_run = w_j_last;
            end
            S_U_BMUL:  o_cmd.op = OP_MUL_GLR;
            S_U_BUPD:  o_cmd.op = OP_BUPD;
            S_U_MUL:   o_cmd.op = OP_MUL_GX;
            S_U_SPLIT: o_cmd.op = OP_SPLIT;
            S_U_MLO:   o_cmd.op = OP_MUL_LO;
            S_U_MHI:   o_cmd.op = OP_MUL_HI;
            S_U_WUPD:  o_cmd.op = OP_WUPD;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_learn_rate = r_learn_rate;
    assign o_row        = r_i;
    assign o_col        = r_j;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the dense layer forward/backward SGD block
`timescale 1ns / 1ps

module tb;
    import dlst_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam int N_IO = 32;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int RANDOM_ITEMS = 360;

    typedef struct {
        logic                     kind;
        logic [FIELD_IDX_BITS-1:0] index;
        logic signed [15:0]       out_value;
        logic                     end_of_run;
    } t_layer_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dlst_in_if  in_ch ();
    dlst_out_if out_ch ();
    dlst_cfg_if cfg_ch ();

    dense_layer_sgd_train_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #1 i_clk = ~i_clk;

    logic signed [15:0] w_mem [N_IO][N_IO];
    logic signed [15:0] b_mem [N_IO];
    logic signed [15:0] x_mem [N_IO];
    logic signed [15:0] g_mem [N_IO];
    logic [15:0]        rate_q;
    logic [5:0]         in_cnt_q;
    logic [5:0]         out_cnt_q;

    t_layer_result layer_out_q[$];
    int err_count = 0;
    int burst_left = 0;
    int items_sent = 0;
    int hold_left = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    function automatic longint clamp61(longint v);
        if (v > (64'sd1 <<< 61)) return 64'sd1 <<< 61;
        if (v < -(64'sd1 <<< 61)) return -(64'sd1 <<< 61);
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic int eff_count(logic [5:0] c);
        return (c > N_IO) ? N_IO : int'(c);
    endfunction

    function automatic longint round12(longint v);
        return (v + 64'sd2048) >>> FRAC_BITS;
    endfunction

    function automatic void push_result(logic k, int idx, longint acc, logic eor);
        t_layer_result r;
        r.kind = k;
        r.index = idx[FIELD_IDX_BITS-1:0];
        r.out_value = sat16(round12(acc));
        r.end_of_run = eor;
        layer_out_q.push_back(r);
    endfunction

    function automatic void layer_step(logic [1:0] mode, logic [4:0] row, logic [4:0] col,
                                       logic signed [15:0] value, logic last);
        int ni, no;
        longint acc, lr, prod, hi, lo, delta;
        ni = eff_count(in_cnt_q);
        no = eff_count(out_cnt_q);
        lr = longint'({48'd0, rate_q});
        case (mode)
            MODE_WEIGHT: w_mem[row][col] = value;
            MODE_BIAS:   b_mem[row] = value;
            MODE_FWD: begin
                x_mem[col] = value;
                if (last) begin
                    for (int i = 0; i < no; i++) begin
                        acc = clamp61(longint'(b_mem[i]) <<< FRAC_BITS);
                        for (int j = 0; j < ni; j++)
                            acc = clamp61(acc + clamp61(longint'(w_mem[i][j]) * x_mem[j]));
                        push_result(KIND_FWD, i, acc, i == no - 1);
                    end
                end
            end
            default: begin
                g_mem[row] = value;
                if (last) begin
                    for (int j = 0; j < ni; j++) begin
                        acc = 0;
                        for (int i = 0; i < no; i++)
                            acc = clamp61(acc + clamp61(longint'(w_mem[i][j]) * g_mem[i]));
                        push_result(KIND_GRAD, j, acc, j == ni - 1);
                    end
                    for (int i = 0; i < no; i++) begin
                        for (int j = 0; j < ni; j++) begin
                            prod = longint'(g_mem[i]) * x_mem[j];
                            hi = prod >>> 28;
                            lo = prod - (hi <<< 28);
                            delta = hi * lr + ((lo * lr + (64'sd1 <<< 27)) >>> 28);
                            w_mem[i][j] = sat16(longint'(w_mem[i][j]) - delta);
                        end
                        b_mem[i] = sat16(longint'(b_mem[i]) -
                                         ((longint'(g_mem[i]) * lr + 64'sd32768) >>> 16));
                    end
                end
            end
        endcase
    endfunction

    task automatic send_item(logic [1:0] mode, logic [4:0] row, logic [4:0] col,
                             logic signed [15:0] value, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= mode;
        in_ch.row   <= row;
        in_ch.col   <= col;
        in_ch.value <= value;
        in_ch.last  <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        layer_step(mode, row, col, value, last);
        burst_left--;
        items_sent++;
    endtask

    task automatic stop_items();
        in_ch.valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_LEARN_RATE: rate_q = data;
            CFG_IN_COUNT:   in_cnt_q = data[5:0];
            CFG_OUT_COUNT:  out_cnt_q = data[5:0];
            default: ;
        endcase
    endtask

    // drain results, then cover the update pass that emits nothing
    task automatic settle();
        int ni, no;
        stop_items();
        while (layer_out_q.size() != 0) @(posedge i_clk);
        ni = eff_count(in_cnt_q);
        no = eff_count(out_cnt_q);
        repeat (no * (3 + 3 * ni) + ni * (2 + 3 * no) + no * (3 + 6 * ni) + 32)
            @(posedge i_clk);
    endtask

    task automatic set_counts(logic [15:0] ni, logic [15:0] no, logic [15:0] lr);
        settle();
        write_reg(CFG_IN_COUNT, ni);
        write_reg(CFG_OUT_COUNT, no);
        write_reg(CFG_LEARN_RATE, lr);
    endtask

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2, 3: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    task automatic send_fwd_vector();
        int n;
        n = eff_count(in_cnt_q);
        if (n == 0) n = 1;
        for (int j = 0; j < n; j++)
            send_item(MODE_FWD, 5'($urandom), 5'(j), rand_value(), j == n - 1);
    endtask

    task automatic send_grad_vector();
        int n;
        n = eff_count(out_cnt_q);
        if (n == 0) n = 1;
        for (int i = 0; i < n; i++)
            send_item(MODE_GRAD, 5'(i), 5'($urandom), rand_value(), i == n - 1);
    endtask

    task automatic test_preload();
        for (int i = 0; i < N_IO; i++) begin
            for (int j = 0; j < N_IO; j++)
                send_item(MODE_WEIGHT, 5'(i), 5'(j), 16'($signed($urandom_range(0, 2047)) - 1024),
                          1'b0);
            send_item(MODE_BIAS, 5'(i), 5'($urandom), rand_value(), 1'b0);
            send_item(MODE_FWD, 5'($urandom), 5'(i), rand_value(), 1'b0);
            send_item(MODE_GRAD, 5'(i), 5'($urandom), rand_value(), 1'b0);
        end
    endtask

    task automatic test_directed();
        set_counts(16'd2, 16'd2, 16'hffff);
        send_item(MODE_WEIGHT, 5'd0, 5'd0, 16'sh7fff, 1'b1);
        send_item(MODE_WEIGHT, 5'd1, 5'd1, 16'sh8000, 1'b1);
        send_item(MODE_BIAS, 5'd0, 5'd31, 16'sh8000, 1'b1);
        send_item(MODE_BIAS, 5'd31, 5'd0, 16'sh7fff, 1'b1);
        send_item(MODE_WEIGHT, 5'd31, 5'd31, 16'sh8000, 1'b0);
        send_item(MODE_FWD, 5'd31, 5'd0, 16'sh7fff, 1'b0);
        send_item(MODE_FWD, 5'd0, 5'd1, 16'sh8000, 1'b1);
        send_item(MODE_GRAD, 5'd0, 5'd31, 16'sh8000, 1'b0);
        send_item(MODE_GRAD, 5'd1, 5'd0, 16'sh7fff, 1'b1);
        send_item(MODE_FWD, 5'd0, 5'd31, 16'sh7fff, 1'b1);
        set_counts(16'd0, 16'd3, 16'd0);
        send_item(MODE_FWD, 5'd0, 5'd0, 16'sd4096, 1'b1);
        send_item(MODE_GRAD, 5'd2, 5'd0, 16'sh7fff, 1'b1);
        set_counts(16'd3, 16'd0, 16'd655);
        send_item(MODE_FWD, 5'd0, 5'd2, 16'sd4096, 1'b1);
        send_item(MODE_GRAD, 5'd31, 5'd0, 16'sh8000, 1'b1);
        settle();
        write_reg(CFG_SPARE, 16'hffff);
        set_counts(16'hffe1, 16'd40, 16'd1);
        send_item(MODE_FWD, 5'd0, 5'd31, 16'sh8000, 1'b1);
        send_item(MODE_GRAD, 5'd31, 5'd31, 16'sh7fff, 1'b1);
    endtask

    task automatic test_backpressure();
        set_counts(16'd4, 16'd16, 16'd3000);
        hold_left = 400;
        send_fwd_vector();
        send_fwd_vector();
        send_grad_vector();
    endtask

    task automatic test_random();
        int pick;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 9))
                    0: set_counts(16'd32, 16'd32, 16'($urandom));
                    1: set_counts(16'($urandom), 16'($urandom), 16'hffff);
                    default: set_counts(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                                        ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom));
                endcase
            end
            pick = $urandom_range(0, 9);
            if (pick < 4) send_fwd_vector();
            else if (pick < 8) send_grad_vector();
            else
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom), 5'($urandom), 5'($urandom), rand_value(),
                              1'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (layer_out_q.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d index=%0d value=%0d", $time,
                             out_ch.kind, out_ch.index, out_ch.out_value);
                    err_count++;
                end else begin
                    t_layer_result e;
                    e = layer_out_q.pop_front();
                    if (e.kind !== out_ch.kind || e.index !== out_ch.index ||
                        e.out_value !== out_ch.out_value || e.end_of_run !== out_ch.end_of_run) begin
                        $display("%0t: expected kind=%0d index=%0d value=%0d end=%0d, got %0d %0d %0d %0d",
                                 $time, e.kind, e.index, e.out_value, e.end_of_run, out_ch.kind,
                                 out_ch.index, out_ch.out_value, out_ch.end_of_run);
                        err_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 9) < 2) stall_left = $urandom_range(1, 7);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.mode   <= MODE_WEIGHT;
        in_ch.row    <= '0;
        in_ch.col    <= '0;
        in_ch.value  <= '0;
        in_ch.last   <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_LEARN_RATE;
        cfg_ch.data  <= '0;
        rate_q    = 16'd655;
        in_cnt_q  = 6'd32;
        out_cnt_q = 6'd32;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_preload();
        test_directed();
        test_backpressure();
        test_random();
        settle();
        if (err_count == 0 && layer_out_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
